// File: hdl/knv_pkg.sv
// Shared types and constants for the k-nearest-neighbor vote block.
// Used by every module in the hdl folder; has no dependencies of its own.

package knv_pkg;

    localparam int NUM_NEIGHBOURS = 8;
    localparam int DIST_W         = 32;
    localparam int LABEL_W        = 16;
    localparam int SLOT_W         = (NUM_NEIGHBOURS > 1) ? $clog2(NUM_NEIGHBOURS) : 1;
    localparam int CNT_W          = $clog2(NUM_NEIGHBOURS + 1);
    localparam int MAJ_LIMIT      = NUM_NEIGHBOURS / 2;

    // Stream payload widths.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_VOTE
    } state_t;

    typedef struct packed {
        logic      clear;
        logic      en;
        slot_idx_t idx;
        dist_t     cand_dist;
        label_t    label;
    } slot_wr_t;

    typedef struct packed {
        logic   unanimous_valid;
        label_t unanimous_label;
        logic   majority_valid;
        label_t majority_label;
    } result_t;

endpackage

// File: hdl/k_nearest_vote.sv
// Top level of the k-nearest-neighbor vote block: stream ports, output register.
// Depends on knv_pkg, knv_slots and knv_ctrl.
//
// Usage:
// The slave stream takes one command per transaction. s_tuser is the command:
// add a candidate (distance and label in s_tdata) or clear all slots. The block
// keeps the NUM_NEIGHBOURS nearest candidates and answers every transaction
// with exactly one master transaction holding the unanimous and majority votes
// over the kept labels after that command.
// Sequence: an add is accepted in ST_IDLE, searches all slots for the maximum
// in ST_SCAN through the shared distance comparator, writes in ST_WRITE and
// makes a vote pass over each slot in ST_VOTE through the shared label-match
// counter before m_tvalid rises. A clear skips search and write and goes
// straight from ST_IDLE to ST_VOTE. s_tready is high only between commands,
// so one command is in flight at a time.
// The result waits in the output register; the next command is accepted while
// it waits, and only its final vote pass stalls until the register is free.
// Reset empties all slots at once and drops any pending result.

module k_nearest_vote
    import knv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // distance[31:0], label[47:32]
    input  logic                 s_tuser,  // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // unanimous_valid[0], unanimous_label[16:1],
                                           // majority_valid[17], majority_label[33:18],
                                           // zero[39:34]
);

    slot_idx_t rd_idx;
    dist_t     rd_dist;
    label_t    rd_label;
    logic      rd_filled;
    logic [NUM_NEIGHBOURS-1:0] filled;
    label_t    labels [NUM_NEIGHBOURS];
    slot_wr_t  wr;
    logic      out_free;
    logic      res_valid;
    result_t   res;

    logic      m_tvalid_reg, m_tvalid_next;
    result_t   res_reg;

    knv_slots u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_idx    (rd_idx),
        .rd_dist   (rd_dist),
        .rd_label  (rd_label),
        .rd_filled (rd_filled),
        .filled    (filled),
        .labels    (labels)
    );

    knv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_dist   (s_tdata[DIST_W-1:0]),
        .in_label  (s_tdata[DIST_W+LABEL_W-1:DIST_W]),
        .rd_idx    (rd_idx),
        .rd_dist   (rd_dist),
        .rd_label  (rd_label),
        .rd_filled (rd_filled),
        .filled    (filled),
        .labels    (labels),
        .wr        (wr),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*LABEL_W - 2){1'b0}},
                       res_reg.majority_label, res_reg.majority_valid,
                       res_reg.unanimous_label, res_reg.unanimous_valid};

endmodule

// File: hdl/knv_slots.sv
// Slot store of the vote block: distances, labels and filled flags.
// Depends on knv_pkg for the slot count, widths and the write struct.

module knv_slots
    import knv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  slot_wr_t  wr,
    input  slot_idx_t rd_idx,
    output dist_t     rd_dist,
    output label_t    rd_label,
    output logic      rd_filled,
    output logic [NUM_NEIGHBOURS-1:0] filled,
    output label_t    labels [NUM_NEIGHBOURS]
);

    dist_t  dist_reg  [NUM_NEIGHBOURS];
    label_t label_reg [NUM_NEIGHBOURS];
    logic [NUM_NEIGHBOURS-1:0] filled_reg;
    logic [NUM_NEIGHBOURS-1:0] filled_next;

    always_comb
    begin
        filled_next = filled_reg;
        if (wr.clear)
        begin
            filled_next = '0;
        end
        else if (wr.en)
        begin
            filled_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    // Contents are only read where the filled flag is set, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.clear)
        begin
            dist_reg[wr.idx]  <= wr.cand_dist;
            label_reg[wr.idx] <= wr.label;
        end
    end

    assign rd_dist   = dist_reg[rd_idx];
    assign rd_label  = label_reg[rd_idx];
    assign rd_filled = filled_reg[rd_idx];
    assign filled    = filled_reg;
    assign labels    = label_reg;

endmodule

// File: hdl/knv_ctrl.sv
// Sequencer of the vote block: one shared distance comparator for the
// maximum search and the replace check, one shared label-match counter for
// the vote passes. Depends on knv_pkg; drives the slot store in knv_slots.

module knv_ctrl
    import knv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      in_cmd,
    input  dist_t     in_dist,
    input  label_t    in_label,
    output slot_idx_t rd_idx,
    input  dist_t     rd_dist,
    input  label_t    rd_label,
    input  logic      rd_filled,
    input  logic [NUM_NEIGHBOURS-1:0] filled,
    input  label_t    labels [NUM_NEIGHBOURS],
    output slot_wr_t  wr,
    input  logic      out_free,
    output logic      res_valid,
    output result_t   res
);

    localparam slot_idx_t LAST_IDX = slot_idx_t'(NUM_NEIGHBOURS - 1);

    state_t    state_reg, state_next;
    slot_idx_t idx_reg, idx_next;

    // Payload registers.
    dist_t     dist_reg, dist_next;
    label_t    label_reg, label_next;
    slot_idx_t pick_reg, pick_next;
    dist_t     pick_dist_reg, pick_dist_next;
    logic      pick_empty_reg, pick_empty_next;
    logic      uv_reg, uv_next;
    logic      mv_reg, mv_next;
    label_t    ml_reg, ml_next;

    // Shared comparator.
    dist_t cmp_a, cmp_b;
    logic  cmp_gt;

    cnt_t  match_cnt;
    logic  uv_now, mv_hit, uv_fin, mv_fin;
    label_t ml_fin;

    assign cmp_gt = cmp_a > cmp_b;

    // Label-match counter over all slots for the slot under the vote pointer.
    always_comb
    begin
        match_cnt = '0;
        for (int j = 0; j < NUM_NEIGHBOURS; j++)
        begin
            match_cnt = match_cnt + cnt_t'(filled[j] && (labels[j] == rd_label));
        end
    end

    assign uv_now = rd_filled && (match_cnt == cnt_t'(NUM_NEIGHBOURS));
    assign mv_hit = rd_filled && (match_cnt > cnt_t'(MAJ_LIMIT));
    assign uv_fin = (idx_reg == '0) ? uv_now : uv_reg;
    assign mv_fin = mv_reg || mv_hit;
    assign ml_fin = mv_reg ? ml_reg : rd_label;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        dist_next       = dist_reg;
        label_next      = label_reg;
        pick_next       = pick_reg;
        pick_dist_next  = pick_dist_reg;
        pick_empty_next = pick_empty_reg;
        uv_next         = uv_reg;
        mv_next         = mv_reg;
        ml_next         = ml_reg;
        in_ready        = 1'b0;
        rd_idx          = idx_reg;
        cmp_a           = rd_dist;
        cmp_b           = pick_dist_reg;
        wr              = '0;
        wr.idx          = pick_reg;
        wr.cand_dist    = dist_reg;
        wr.label        = label_reg;
        res_valid       = 1'b0;
        res             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dist_next       = in_dist;
                    label_next      = in_label;
                    idx_next        = '0;
                    pick_next       = '0;
                    pick_dist_next  = '0;
                    pick_empty_next = 1'b0;
                    uv_next         = 1'b0;
                    mv_next         = 1'b0;
                    ml_next         = '0;
                    if (in_cmd == CMD_CLEAR)
                    begin
                        wr.clear   = 1'b1;
                        state_next = ST_VOTE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // Find the first empty slot, otherwise the first slot of largest distance.
            ST_SCAN:
            begin
                if (!pick_empty_reg)
                begin
                    if (!rd_filled)
                    begin
                        pick_next       = idx_reg;
                        pick_empty_next = 1'b1;
                    end
                    else if (idx_reg == '0 || cmp_gt)
                    begin
                        pick_next      = idx_reg;
                        pick_dist_next = rd_dist;
                    end
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_WRITE:
            begin
                cmp_a      = pick_dist_reg;
                cmp_b      = dist_reg;
                wr.en      = pick_empty_reg || cmp_gt;
                idx_next   = '0;
                state_next = ST_VOTE;
            end

            ST_VOTE:
            begin
                if (idx_reg == '0)
                begin
                    uv_next = uv_now;
                end
                if (!mv_reg && mv_hit)
                begin
                    mv_next = 1'b1;
                    ml_next = rd_label;
                end
                if (idx_reg == LAST_IDX)
                begin
                    // Slots do not change here, so the result holds while waiting.
                    if (out_free)
                    begin
                        res_valid           = 1'b1;
                        res.unanimous_valid = uv_fin;
                        // When unanimous every label equals the label of the first slot.
                        res.unanimous_label = uv_fin ? labels[0] : '0;
                        res.majority_valid  = mv_fin;
                        res.majority_label  = mv_fin ? ml_fin : '0;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg       <= dist_next;
        label_reg      <= label_next;
        pick_reg       <= pick_next;
        pick_dist_reg  <= pick_dist_next;
        pick_empty_reg <= pick_empty_next;
        uv_reg         <= uv_next;
        mv_reg         <= mv_next;
        ml_reg         <= ml_next;
    end

endmodule

// File: hdl/knv_checker.sv
// Port-level checks of the k-nearest-neighbor vote block, bound to the top level.
// Depends on knv_pkg and on the port names of k_nearest_vote.

module knv_checker
    import knv_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic   uv, mv;
    label_t ul, ml;

    assign uv = m_tdata[0];
    assign ul = m_tdata[LABEL_W:1];
    assign mv = m_tdata[LABEL_W+1];
    assign ml = m_tdata[2*LABEL_W+1:LABEL_W+2];

    // Only one command is in flight, so the block cannot take two in a row.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("knv: accepted a command while another was in flight");

    // A unanimous vote is always a majority vote for the same label.
    a_unan_is_major: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && uv) |-> (mv && (ml == ul)))
        else $error("knv: unanimous result without matching majority");

    // A decision that is not valid reports label zero.
    a_zero_labels: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((uv || (ul == '0)) && (mv || (ml == '0))))
        else $error("knv: label set on an invalid decision");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("knv: result changed while stalled");

endmodule

bind k_nearest_vote knv_checker u_knv_checker (.*);

// File: verif/k_nearest_vote_tb.sv
// Self-checking testbench for the k-nearest-neighbor vote block: drives commands on the
// slave stream, predicts each vote in a small scoreboard class and checks the master stream.
// Depends on knv_pkg and k_nearest_vote from the hdl folder.

module k_nearest_vote_tb
    import knv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 4 * NUM_NEIGHBOURS + 8;
    localparam int RANDOM_ITEMS = 1450;

    // Tracks the kept neighbors and holds the votes that are still owed by the block.
    class vote_scoreboard;
        dist_t   near_dist[NUM_NEIGHBOURS];
        label_t  near_label[NUM_NEIGHBOURS];
        bit      filled[NUM_NEIGHBOURS];
        result_t owed_votes[$];
        int      errors = 0;

        function void note_command(logic cmd, dist_t cand_dist, label_t label);
            int      i;
            int      j;
            int      pick;
            int      count;
            bit      pick_empty;
            dist_t   pick_dist;
            result_t vote;

            if (cmd == CMD_CLEAR)
            begin
                for (i = 0; i < NUM_NEIGHBOURS; i++)
                    filled[i] = 1'b0;
            end
            else
            begin
                // The slot to evict is the lowest-numbered farthest one; an empty slot wins.
                pick = 0;
                pick_empty = !filled[0];
                pick_dist = filled[0] ? near_dist[0] : '0;
                for (i = 1; i < NUM_NEIGHBOURS && !pick_empty; i++)
                begin
                    if (!filled[i])
                    begin
                        pick = i;
                        pick_empty = 1'b1;
                    end
                    else if (near_dist[i] > pick_dist)
                    begin
                        pick = i;
                        pick_dist = near_dist[i];
                    end
                end
                if (pick_empty || cand_dist < pick_dist)
                begin
                    near_dist[pick] = cand_dist;
                    near_label[pick] = label;
                    filled[pick] = 1'b1;
                end
            end

            vote = '0;
            vote.unanimous_valid = 1'b1;
            for (i = 0; i < NUM_NEIGHBOURS; i++)
                if (!filled[i] || near_label[i] != near_label[0])
                    vote.unanimous_valid = 1'b0;
            if (vote.unanimous_valid)
                vote.unanimous_label = near_label[0];

            for (i = 0; i < NUM_NEIGHBOURS && !vote.majority_valid; i++)
            begin
                if (filled[i])
                begin
                    count = 0;
                    for (j = 0; j < NUM_NEIGHBOURS; j++)
                        if (filled[j] && near_label[j] == near_label[i])
                            count++;
                    if (count > MAJ_LIMIT)
                    begin
                        vote.majority_valid = 1'b1;
                        vote.majority_label = near_label[i];
                    end
                end
            end
            owed_votes.insert(owed_votes.size(), vote);
        endfunction

        function void check_vote(logic [M_TDATA_W-1:0] tdata);
            result_t got;
            result_t want;

            got.unanimous_valid = tdata[0];
            got.unanimous_label = tdata[16:1];
            got.majority_valid  = tdata[17];
            got.majority_label  = tdata[33:18];
            if (owed_votes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected vote transaction, data %h", $realtime, tdata);
                return;
            end
            want = owed_votes.pop_front();
            if (got.unanimous_valid !== want.unanimous_valid
                || got.unanimous_label !== want.unanimous_label
                || got.majority_valid !== want.majority_valid
                || got.majority_label !== want.majority_label)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: vote mismatch: expected uv=%b ul=%h mv=%b ml=%h, ",
                              "got uv=%b ul=%h mv=%b ml=%h"},
                             $realtime, want.unanimous_valid, want.unanimous_label,
                             want.majority_valid, want.majority_label,
                             got.unanimous_valid, got.unanimous_label,
                             got.majority_valid, got.majority_label);
            end
        endfunction

        function int owed();
            return owed_votes.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int send_idle_pct = 22;
    int recv_idle_pct = 65;
    int quiet_cycles = 0;

    vote_scoreboard sb = new();

    k_nearest_vote u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Result side: check each vote transaction, then decide whether to stall next cycle.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_vote(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("k_nearest_vote_tb: done, errors");
                $finish;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the command transaction completes.
    task automatic send_command(input logic cmd, input dist_t cand_dist, input label_t label);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {label, cand_dist};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_command(cmd, cand_dist, label);
    endtask

    task automatic drain_votes();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.owed() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        int i;

        send_command(CMD_CLEAR, '1, '1);
        send_command(CMD_ADD, '1, '1);
        send_command(CMD_ADD, '0, '0);
        for (i = 1; i <= 6; i++)
            send_command(CMD_ADD, dist_t'(100 * i), label_t'(5));
        // Slot 0 holds the farthest neighbor and is evicted; an equal distance is dropped.
        send_command(CMD_ADD, dist_t'(600), label_t'(9));
        send_command(CMD_ADD, dist_t'(600), label_t'(7));
        send_command(CMD_ADD, dist_t'(1), label_t'(5));
        send_command(CMD_CLEAR, '0, '0);
        for (i = 0; i < NUM_NEIGHBOURS; i++)
            send_command(CMD_ADD, dist_t'(1000 - i), label_t'(16'hA5A5));
        // Four closer neighbors of another class leave an exact tie, which is no majority.
        for (i = 0; i < 4; i++)
            send_command(CMD_ADD, dist_t'(10 + i), label_t'(3));
    endtask

    // Mostly well-formed runs: a clear followed by adds drawn from a few classes.
    task automatic run_random(input int total);
        int     sent;
        int     k;
        int     run_len;
        int     pool_size;
        dist_t  span;
        dist_t  cand_dist;
        label_t label;
        label_t pool[3];

        sent = 0;
        while (sent < total)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_command(logic'($urandom_range(1)), dist_t'($urandom), label_t'($urandom));
                sent++;
            end
            else
            begin
                send_command(CMD_CLEAR, dist_t'($urandom), label_t'($urandom));
                sent++;
                for (k = 0; k < 3; k++)
                    pool[k] = label_t'($urandom);
                pool_size = $urandom_range(1, 3);
                span = ($urandom_range(3) == 0) ? '1 : dist_t'($urandom_range(1, 64));
                run_len = $urandom_range(1, 24);
                for (k = 0; k < run_len && sent < total; k++)
                begin
                    label = ($urandom_range(9) == 0) ? label_t'($urandom)
                                                     : pool[$urandom_range(pool_size - 1)];
                    cand_dist = (span == '1) ? dist_t'($urandom)
                                             : dist_t'($urandom_range(0, span));
                    send_command(CMD_ADD, cand_dist, label);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_ITEMS / 3);
        drain_votes();

        send_idle_pct = 65;
        recv_idle_pct = 22;
        run_random(RANDOM_ITEMS / 3);
        drain_votes();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain_votes();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("k_nearest_vote_tb: done, clean");
        else
            $display("k_nearest_vote_tb: done, errors");
        $finish;
    end

endmodule
